[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers used by task_partition_sigmoid_probability.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpsp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TPSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpsp assertion failed");

`endif

[rtl/core/tpsp_pkg.sv]
// ----------------------------------------------------------------------------
// tpsp_pkg
// Types and constants of the task partition sigmoid probability block.
// ----------------------------------------------------------------------------
package tpsp_pkg;

  // Fixed point
  localparam int FRAC_BITS = 16;
  localparam int RATIO_QW  = 32;
  localparam int PROB_QW   = 17;
  localparam int THETA_W   = 21;
  localparam int EXP_TERMS = 14;
  localparam int EXP_SQRS  = 4;

  localparam logic [32:0] RATIO_SAT = 33'h1_0000_0000;
  localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
  localparam logic [THETA_W-1:0] THETA_MAX = 21'h10_0000;
  localparam logic [16:0] PROB_ONE  = 17'd65536;
  localparam logic [47:0] SIG_NUM_BASE = 48'h8000_4000_0000;

  // Configuration port
  localparam int APB_AW = 4;
  localparam logic [15:0] GAIN_RST   = 16'd256;
  localparam logic [15:0] OFFSET_RST = 16'd256;
  localparam logic [16:0] SCALE_RST  = 17'd65536;

  typedef enum logic [1:0] {
    CFG_GAIN   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_SCALE  = 2'd2
  } cfg_addr_t;

  // Control carried alongside the exponential pipeline
  typedef struct packed {
    logic valid;
    logic neg;
  } exp_ctl_t;

  // floor(2^32 / n) for the series divisors
  function automatic logic [31:0] recip(input int n);
    logic [31:0] r;
    unique case (n)
      2:       r = 32'd2147483648;
      3:       r = 32'd1431655765;
      4:       r = 32'd1073741824;
      5:       r = 32'd858993459;
      6:       r = 32'd715827882;
      7:       r = 32'd613566756;
      8:       r = 32'd536870912;
      9:       r = 32'd477218588;
      10:      r = 32'd429496729;
      11:      r = 32'd390451572;
      12:      r = 32'd357913941;
      13:      r = 32'd330382099;
      14:      r = 32'd306783378;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tpsp_if.sv]
// ----------------------------------------------------------------------------
// tpsp_if
// Valid/ready channels: time estimate beats in, probability beats out.
// ----------------------------------------------------------------------------
interface tpsp_times_if #(parameter int TIME_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] whole_time;
  logic [TIME_BITS-1:0] first_part_time;
  logic [TIME_BITS-1:0] second_part_time;

  modport source (output valid, whole_time, first_part_time, second_part_time,
                  input ready);
  modport sink (input valid, whole_time, first_part_time, second_part_time,
                output ready);
endinterface

interface tpsp_prob_if;
  logic        valid;
  logic        ready;
  logic [15:0] split_probability;

  modport source (output valid, split_probability, input ready);
  modport sink (input valid, split_probability, output ready);
endinterface

[rtl/core/tpsp_div.sv]
// ----------------------------------------------------------------------------
// tpsp_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module tpsp_div #(
  parameter int NW    = 48,
  parameter int DW    = 33,
  parameter int QW    = 17,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             v   [0:QW];
  logic [NW-1:0]    n_s [0:QW];
  logic [DW-1:0]    d_s [0:QW];
  logic [DW-1:0]    r_s [0:QW];
  logic [QW-1:0]    q_s [0:QW];
  logic [TAG_W-1:0] t_s [0:QW];
  logic [DW-1:0]    r_init;

  // Dividend bits above the quotient seed the remainder (must be below den)
  generate
    if (NW > QW) begin : g_hi
      assign r_init = DW'(num[NW-1:QW]);
    end else begin : g_nohi
      assign r_init = '0;
    end
  endgenerate

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0] <= num;
      d_s[0] <= den;
      r_s[0] <= r_init;
      q_s[0] <= '0;
      t_s[0] <= in_tag;
    end
  end

  // One quotient bit per stage, MSB first
  generate
    for (genvar k = 1; k <= QW; k++) begin : g_bit
      localparam int BI = QW - k;
      logic          nb;
      logic [DW:0]   sh;
      logic [DW:0]   sub;
      logic          ge;

      if (BI < NW) begin : g_nb
        assign nb = n_s[k-1][BI];
      end else begin : g_nz
        assign nb = 1'b0;
      end

      assign sh  = {r_s[k-1], nb};
      assign ge  = sh >= {1'b0, d_s[k-1]};
      assign sub = sh - {1'b0, d_s[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_s[k] <= n_s[k-1];
          d_s[k] <= d_s[k-1];
          r_s[k] <= ge ? sub[DW-1:0] : sh[DW-1:0];
          q_s[k] <= (q_s[k-1] << 1) | QW'(ge);
          t_s[k] <= t_s[k-1];
        end
      end
    end
  endgenerate

  assign out_valid = v[QW];
  assign quo       = q_s[QW];
  assign out_tag   = t_s[QW];

endmodule

[rtl/core/tpsp_exp.sv]
// ----------------------------------------------------------------------------
// tpsp_exp
// exp(-m) in Q31: Taylor series of exp(-m/16) through the x^14 term, then four squarings.
// ----------------------------------------------------------------------------
module tpsp_exp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  tpsp_pkg::exp_ctl_t           in_ctl,
  input  logic [tpsp_pkg::THETA_W-1:0] mag,
  output tpsp_pkg::exp_ctl_t           out_ctl,
  output logic [31:0]                  e
);

  localparam int NT = tpsp_pkg::EXP_TERMS;
  localparam int NS = tpsp_pkg::EXP_SQRS;
  localparam bit LAST_SUB = (tpsp_pkg::EXP_TERMS % 2) == 1;

  // Term stage outputs (index 1 is the entry stage)
  tpsp_pkg::exp_ctl_t c_ctl  [1:NT];
  logic [31:0]        c_term [1:NT];
  logic [31:0]        c_x    [1:NT];
  logic signed [34:0] c_acc  [1:NT];

  // Product and reciprocal stages
  tpsp_pkg::exp_ctl_t a_ctl  [2:NT];
  logic [63:0]        a_prod [2:NT];
  logic [31:0]        a_x    [2:NT];
  logic signed [34:0] a_acc  [2:NT];
  tpsp_pkg::exp_ctl_t b_ctl  [2:NT];
  logic [63:0]        b_pr   [2:NT];
  logic [31:0]        b_t1   [2:NT];
  logic [31:0]        b_x    [2:NT];
  logic signed [34:0] b_acc  [2:NT];

  // Squaring chain
  tpsp_pkg::exp_ctl_t s_ctl [0:NS];
  logic [31:0]        sq    [0:NS];

  logic signed [34:0] f_acc;

  // Entry: x = m / 16 in Q31, accumulator starts at one
  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl[1].valid <= 1'b0;
    end else if (en) begin
      c_ctl[1] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_term[1] <= {mag, 11'b0};
      c_x[1]    <= {mag, 11'b0};
      c_acc[1]  <= $signed({3'b0, tpsp_pkg::Q31_ONE});
    end
  end

  generate
    for (genvar n = 2; n <= NT; n++) begin : g_term
      localparam bit          SUB_PREV = ((n - 1) % 2) == 1;
      localparam logic [31:0] RCP      = tpsp_pkg::recip(n);
      localparam logic [4:0]  NDIV     = 5'(n);
      logic signed [34:0] prev_s;
      logic [63:0]        prod;
      logic [31:0]        t1;
      logic [63:0]        pr;
      logic [31:0]        qe;
      logic [36:0]        qn;
      logic [36:0]        rem;

      assign prev_s = $signed({3'b0, c_term[n-1]});
      assign prod   = c_term[n-1] * c_x[n-1];
      assign t1     = a_prod[n][62:31];
      assign pr     = t1 * RCP;
      assign qe     = b_pr[n][63:32];
      assign qn     = qe * NDIV;
      assign rem    = {5'b0, b_t1[n]} - qn;

      // Valid chain through the three stages of this term
      always_ff @(posedge clk) begin
        if (rst) begin
          a_ctl[n].valid <= 1'b0;
          b_ctl[n].valid <= 1'b0;
          c_ctl[n].valid <= 1'b0;
        end else if (en) begin
          a_ctl[n] <= c_ctl[n-1];
          b_ctl[n] <= a_ctl[n];
          c_ctl[n] <= b_ctl[n];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          // term(n-1) * x, and fold term(n-1) into the sum
          a_prod[n] <= prod;
          a_x[n]    <= c_x[n-1];
          a_acc[n]  <= SUB_PREV ? c_acc[n-1] - prev_s : c_acc[n-1] + prev_s;
          // divide by n through the reciprocal
          b_pr[n]   <= pr;
          b_t1[n]   <= t1;
          b_x[n]    <= a_x[n];
          b_acc[n]  <= a_acc[n];
          // estimate is exact or one low
          c_term[n] <= (rem >= 37'(NDIV)) ? qe + 32'd1 : qe;
          c_x[n]    <= b_x[n];
          c_acc[n]  <= b_acc[n];
        end
      end
    end
  endgenerate

  // Last term, then clamp to [0, 1]
  assign f_acc = LAST_SUB ? c_acc[NT] - $signed({3'b0, c_term[NT]})
                          : c_acc[NT] + $signed({3'b0, c_term[NT]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl[0].valid <= 1'b0;
    end else if (en) begin
      s_ctl[0] <= c_ctl[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_acc < 35'sd0) begin
        sq[0] <= '0;
      end else if (f_acc > $signed({3'b0, tpsp_pkg::Q31_ONE})) begin
        sq[0] <= tpsp_pkg::Q31_ONE;
      end else begin
        sq[0] <= f_acc[31:0];
      end
    end
  end

  // Squarings: exp(-m) = exp(-m/16)^16
  generate
    for (genvar j = 1; j <= NS; j++) begin : g_sq
      logic [63:0] sp;
      assign sp = sq[j-1] * sq[j-1];

      always_ff @(posedge clk) begin
        if (rst) begin
          s_ctl[j].valid <= 1'b0;
        end else if (en) begin
          s_ctl[j] <= s_ctl[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq[j] <= sp[62:31];
        end
      end
    end
  endgenerate

  assign out_ctl = s_ctl[NS];
  assign e       = sq[NS];

endmodule

[rtl/core/task_partition_sigmoid_probability.sv]
// ----------------------------------------------------------------------------
// task_partition_sigmoid_probability
// Partition probability as a sigmoid of the whole-to-subtask time ratio.
// ----------------------------------------------------------------------------
// Usage:
//   times: valid/ready channel, one beat carries the whole task estimate and
//   the two subtask estimates. prob: valid/ready channel, one beat per input
//   beat, carrying split_probability in unsigned Q0.16, in input order.
//   APB port: gain at 0x0, offset at 0x4, scale at 0x8; write only while idle.
// Timing:
//   Fully pipelined, one beat per cycle while the output is not stalled.
//   The depth is set by the two pipelined restoring dividers (33 and 18
//   stages) and the series of the exponential unit (45 stages).
// Reset:
//   rst is synchronous; it empties every stage and the output register and
//   loads the registers with gain 1.0, offset 1.0, scale 1.0.
// Backpressure:
//   While the output beat waits, the pipeline keeps moving until a result
//   sits in its last stage; then all stages hold and times.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_partition_sigmoid_probability #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  tpsp_times_if.sink                  times,
  tpsp_prob_if.source                 prob,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpsp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SW = TIME_BITS + 1;
  localparam int FB = tpsp_pkg::FRAC_BITS;

  // Configuration registers
  logic [15:0] gain;
  logic [15:0] offset;
  logic [16:0] scale;
  logic        cfg_wr;

  // Pipeline advance
  logic adv;

  // Front stages
  logic                 f0_v;
  logic [TIME_BITS-1:0] f0_t;
  logic [SW-1:0]        f0_s;
  logic                 f1_v, f1_gt, f1_zero;
  logic [SW-1:0]        f1_n, f1_d;
  logic                 f2_v, f2_gt, f2_zero, f2_ovf;
  logic [SW-1:0]        f2_n, f2_d;
  logic                 f1_gt_c;

  // Ratio divider
  logic                           q1_v;
  logic [tpsp_pkg::RATIO_QW-1:0]  q1;
  logic [2:0]                     q1_tag;

  // Theta stages
  logic               r_v;
  logic signed [34:0] r_diff;
  logic [32:0]        ratio;
  logic signed [34:0] ratio_s;
  logic signed [34:0] off_s;
  logic               a_v, a_neg;
  logic [32:0]        a_abs;
  logic               m_v, m_neg;
  logic [48:0]        m_prod;
  logic               c_v, c_neg;
  logic [tpsp_pkg::THETA_W-1:0] c_mag;
  logic [40:0]        m_full;
  logic [34:0]        r_neg_diff;

  // Exponential and sigmoid divider
  tpsp_pkg::exp_ctl_t x_ctl, e_ctl;
  logic [31:0]        e_val;
  logic               dn_v, dn_neg;
  logic [32:0]        dn_den;
  logic [47:0]        dn_num;
  logic               q2_v;
  logic [tpsp_pkg::PROB_QW-1:0] q2;
  logic               q2_neg;

  // Back end
  logic        p_v;
  logic [16:0] p_val;
  logic [16:0] p_clip;
  logic        y_v;
  logic [34:0] y_val;
  logic        ov;
  logic [15:0] o_data;

  // --------------------------------------------------------------------------
  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= tpsp_pkg::GAIN_RST;
      offset <= tpsp_pkg::OFFSET_RST;
      scale  <= tpsp_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (tpsp_pkg::cfg_addr_t'(paddr[tpsp_pkg::APB_AW-1:2]))
        tpsp_pkg::CFG_GAIN:   gain   <= pwdata[15:0];
        tpsp_pkg::CFG_OFFSET: offset <= pwdata[15:0];
        tpsp_pkg::CFG_SCALE:  scale  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tpsp_pkg::cfg_addr_t'(paddr[tpsp_pkg::APB_AW-1:2]))
      tpsp_pkg::CFG_GAIN:   prdata = 32'(gain);
      tpsp_pkg::CFG_OFFSET: prdata = 32'(offset);
      tpsp_pkg::CFG_SCALE:  prdata = 32'(scale);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: everything moves unless a result is stuck behind the output
  assign adv         = !y_v || !ov || prob.ready;
  assign times.ready = adv;

  // --------------------------------------------------------------------------
  // F0: subtask sum
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
    end else if (adv) begin
      f0_v <= times.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_t <= times.whole_time;
      f0_s <= {1'b0, times.first_part_time} + {1'b0, times.second_part_time};
    end
  end

  // F1: pick numerator and divisor
  assign f1_gt_c = {1'b0, f0_t} > f0_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (adv) begin
      f1_v <= f0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_gt   <= f1_gt_c;
      f1_n    <= f1_gt_c ? {1'b0, f0_t} : f0_s;
      f1_d    <= f1_gt_c ? f0_s : {1'b0, f0_t};
      f1_zero <= f1_gt_c ? (f0_s == '0) : (f0_t == '0);
    end
  end

  // F2: ratio saturates when the integer part reaches 65536
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (adv) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_gt   <= f1_gt;
      f2_zero <= f1_zero;
      f2_n    <= f1_n;
      f2_d    <= f1_d;
      f2_ovf  <= (f1_n >> FB) >= f1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio in Q16.16
  tpsp_div #(
    .NW    (SW + FB),
    .DW    (SW),
    .QW    (tpsp_pkg::RATIO_QW),
    .TAG_W (3)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f2_v),
    .num       ({f2_n, FB'(0)}),
    .den       (f2_d),
    .in_tag    ({f2_gt, f2_zero, f2_ovf}),
    .out_valid (q1_v),
    .quo       (q1),
    .out_tag   (q1_tag)
  );

  // --------------------------------------------------------------------------
  // R: signed difference against the offset
  assign ratio      = q1_tag[0] ? tpsp_pkg::RATIO_SAT : {1'b0, q1};
  assign ratio_s    = $signed({2'b0, ratio});
  assign off_s      = $signed({11'b0, offset, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (adv) begin
      r_v <= q1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q1_tag[1]) begin
        r_diff <= '0;
      end else if (q1_tag[2]) begin
        r_diff <= ratio_s - off_s;
      end else begin
        r_diff <= off_s - ratio_s;
      end
    end
  end

  // A: magnitude and sign
  assign r_neg_diff = 35'(-r_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg <= r_diff[34];
      a_abs <= r_diff[34] ? r_neg_diff[32:0] : r_diff[32:0];
    end
  end

  // M: gain product
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_neg  <= a_neg;
      m_prod <= gain * a_abs;
    end
  end

  // C: theta magnitude clamped to 16.0; zero theta counts as positive
  assign m_full = m_prod[48:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg <= m_neg && (m_full != '0);
      c_mag <= (m_full > 41'(tpsp_pkg::THETA_MAX)) ? tpsp_pkg::THETA_MAX
                                                    : m_full[tpsp_pkg::THETA_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // exp(-|theta|)
  assign x_ctl = '{valid: c_v, neg: c_neg};

  tpsp_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_ctl  (x_ctl),
    .mag     (c_mag),
    .out_ctl (e_ctl),
    .e       (e_val)
  );

  // Dn: denominator 1 + e and rounded dividend 2^47 + den/2
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_v <= 1'b0;
    end else if (adv) begin
      dn_v <= e_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_neg <= e_ctl.neg;
      dn_den <= {1'b0, e_val} + {1'b0, tpsp_pkg::Q31_ONE};
      dn_num <= tpsp_pkg::SIG_NUM_BASE + 48'(e_val >> 1);
    end
  end

  tpsp_div #(
    .NW    (48),
    .DW    (33),
    .QW    (tpsp_pkg::PROB_QW),
    .TAG_W (1)
  ) u_sig_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dn_v),
    .num       (dn_num),
    .den       (dn_den),
    .in_tag    (dn_neg),
    .out_valid (q2_v),
    .quo       (q2),
    .out_tag   (q2_neg)
  );

  // --------------------------------------------------------------------------
  // P: sigmoid, mirrored for negative theta
  assign p_clip = (q2 > tpsp_pkg::PROB_ONE) ? tpsp_pkg::PROB_ONE : q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= q2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_val <= q2_neg ? tpsp_pkg::PROB_ONE - p_clip : p_clip;
    end
  end

  // Y: gamma scaling with rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      y_v <= 1'b0;
    end else if (adv) begin
      y_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_val <= 35'(p_val) * 35'(scale) + 35'd32768;
    end
  end

  // Output register, saturated at 65535
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      ov <= (adv && y_v) || (ov && !prob.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && y_v) begin
      o_data <= (y_val[34:32] != '0) ? 16'hFFFF : y_val[31:16];
    end
  end

  assign prob.valid             = ov;
  assign prob.split_probability = o_data;

  // --------------------------------------------------------------------------
  // Checks
  `TPSP_ASSERT_NXT(a_beat_enters, clk, rst, times.valid && times.ready, f0_v)
  `TPSP_ASSERT_IMP(a_stall_holds_input, clk, rst, ov && !prob.ready && y_v, !times.ready)
  `TPSP_ASSERT_IMP(a_sigmoid_range, clk, rst, q2_v, q2 <= tpsp_pkg::PROB_ONE)

endmodule

[test/tb_task_partition_sigmoid_probability_checker.sv]
// ----------------------------------------------------------------------------
// tb_task_partition_sigmoid_probability_checker
// Watches the time and probability channels and the register port, predicts
// each split probability in fixed point and compares it with the output beat.
// ----------------------------------------------------------------------------
module tb_task_partition_sigmoid_probability_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] whole_time,
  input  logic [31:0] first_part_time,
  input  logic [31:0] second_part_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] split_probability,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);

  logic [15:0] gain_q;
  logic [15:0] offset_q;
  logic [16:0] scale_q;
  logic [15:0] prob_queue[$];

  // floor(n * 2^16 / d), saturated at 2^32
  function automatic logic [63:0] ratio_q16(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    q = n / d;
    if (q >= 64'd65536) return 64'h1_0000_0000;
    return (n << 16) / d;
  endfunction

  // exp(-m) in Q31: Taylor series of exp(-m/16), then four squarings
  function automatic logic [63:0] exp_neg(input logic [63:0] m);
    logic [63:0] x, term, e;
    longint acc;
    x = m << 11;
    term = 64'h8000_0000;
    acc = 64'sh8000_0000;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x) >> 31) / n;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sh8000_0000) acc = 64'sh8000_0000;
    e = acc;
    for (int n = 0; n < 4; n++) e = (e * e) >> 31;
    return e;
  endfunction

  function automatic logic [15:0] predict_probability(input logic [31:0] t32,
      input logic [31:0] a32, input logic [31:0] b32);
    logic [63:0] t, s, mag, e, den, p, res;
    longint offs, diff, th;
    logic neg;
    t = t32;
    s = 64'(a32) + 64'(b32);
    offs = longint'(offset_q) << 8;
    diff = 0;
    if (t > s) begin
      if (s != 0) diff = longint'(ratio_q16(t, s)) - offs;
    end else if (t != 0) begin
      diff = offs - longint'(ratio_q16(s, t));
    end
    th = longint'(gain_q) * diff;
    neg = th < 0;
    mag = neg ? -th : th;
    mag = mag >> 8;
    if (mag > 64'd1048576) mag = 64'd1048576;
    if (mag == 0) neg = 1'b0;
    e = exp_neg(mag);
    den = 64'h8000_0000 + e;
    p = ((64'd1 << 47) + (den >> 1)) / den;
    if (p > 64'd65536) p = 64'd65536;
    if (neg) p = 64'd65536 - p;
    res = (p * scale_q + 64'd32768) >> 16;
    if (res > 64'd65535) res = 64'd65535;
    return res[15:0];
  endfunction

  assign pending_count = prob_queue.size();

  // Register shadow, input prediction and output compare
  always @(posedge clk) begin
    if (rst) begin
      gain_q <= tpsp_pkg::GAIN_RST;
      offset_q <= tpsp_pkg::OFFSET_RST;
      scale_q <= tpsp_pkg::SCALE_RST;
      fail_count <= 0;
      prob_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tpsp_pkg::CFG_GAIN:   gain_q <= pwdata[15:0];
          tpsp_pkg::CFG_OFFSET: offset_q <= pwdata[15:0];
          tpsp_pkg::CFG_SCALE:  scale_q <= pwdata[16:0];
          default:    ;
        endcase
      end
      if (in_valid && in_ready)
        prob_queue.push_back(predict_probability(whole_time, first_part_time,
                                                 second_part_time));
      if (out_valid && out_ready) begin
        if (prob_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0d", $time,
                   split_probability);
          fail_count <= fail_count + 1;
        end else begin
          if (prob_queue[0] !== split_probability) begin
            $display("%0t: split_probability expected %0d actual %0d", $time,
                     prob_queue[0], split_probability);
            fail_count <= fail_count + 1;
          end
          void'(prob_queue.pop_front());
        end
      end
    end
  end
endmodule

[test/tb_task_partition_sigmoid_probability.sv]
// ----------------------------------------------------------------------------
// tb_task_partition_sigmoid_probability
// Drives time estimate beats and register writes through several idle and
// stall phases; the checker predicts and compares every probability beat.
// ----------------------------------------------------------------------------
module tb_task_partition_sigmoid_probability;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  tpsp_times_if #(.TIME_BITS(32)) times ();
  tpsp_prob_if prob ();

  task_partition_sigmoid_probability #(.TIME_BITS(32)) i_dut (
    .clk(clk), .rst(rst), .times(times.sink), .prob(prob.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tb_task_partition_sigmoid_probability_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(times.valid), .in_ready(times.ready),
    .whole_time(times.whole_time), .first_part_time(times.first_part_time),
    .second_part_time(times.second_part_time),
    .out_valid(prob.valid), .out_ready(prob.ready),
    .split_probability(prob.split_probability),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #1 clk = ~clk;

  initial begin
    times.valid = 1'b0;
    times.whole_time = '0;
    times.first_part_time = '0;
    times.second_part_time = '0;
    prob.ready = 1'b0;
  end

  // Receiver: random stalls, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      prob.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      prob.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input tpsp_pkg::cfg_addr_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // One beat; idle gaps come before it, valid stays up between beats
  task automatic send_times(input logic [31:0] t, input logic [31:0] a,
                            input logic [31:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      times.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    times.valid <= 1'b1;
    times.whole_time <= t;
    times.first_part_time <= a;
    times.second_part_time <= b;
    do @(posedge clk); while (!times.ready);
    @(negedge clk);
  endtask

  task automatic drain;
    times.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_time(input int bits);
    logic [31:0] v;
    v = $urandom;
    return (bits >= 32) ? v : v >> (32 - bits);
  endfunction

  // Random triples: mostly near-balanced ratios, some wide and extreme
  task automatic send_random(input int count);
    logic [31:0] t, a, b;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      a = rand_time($urandom_range(32, 1));
      b = rand_time($urandom_range(32, 1));
      if (kind < 6) begin
        t = a + b + $urandom_range(32) - 16 + (($urandom_range(1) == 1) ?
            ((a >> $urandom_range(4)) & 32'h7fff_ffff) : 32'd0);
      end else if (kind < 8) begin
        t = rand_time($urandom_range(32, 1));
      end else begin
        t = $urandom_range(1) ? 32'd0 : 32'hffff_ffff;
        if ($urandom_range(1)) a = '0;
      end
      send_times(t, a, b);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes and special cases at reset settings
    send_times(32'd0, 32'd0, 32'd0);
    send_times(32'd10, 32'd0, 32'd0);
    send_times(32'd0, 32'd5, 32'd7);
    send_times(32'hffff_ffff, 32'd1, 32'd0);
    send_times(32'd1, 32'hffff_ffff, 32'hffff_ffff);
    send_times(32'd100, 32'd50, 32'd50);
    send_times(32'd101, 32'd50, 32'd50);
    send_times(32'd99, 32'd50, 32'd50);
    send_times(32'd300, 32'd50, 32'd50);
    send_times(32'd20, 32'd50, 32'd50);
    send_times(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_times(32'haaaa_5555, 32'h5555_aaaa, 32'h0f0f_f0f0);
    drain();

    // Gamma above one, saturating; largest gain and offset
    write_reg(tpsp_pkg::CFG_SCALE, 32'h0001_ffff);
    write_reg(tpsp_pkg::CFG_GAIN, 32'h0000_ffff);
    write_reg(tpsp_pkg::CFG_OFFSET, 32'h0000_ffff);
    send_times(32'd1000, 32'd1, 32'd1);
    send_times(32'd2, 32'd1, 32'd1);
    send_times(32'd1, 32'd500, 32'd500);
    send_times(32'hffff_ffff, 32'd0, 32'd1);
    drain();
    write_reg(tpsp_pkg::CFG_GAIN, 32'd0);
    write_reg(tpsp_pkg::CFG_OFFSET, 32'd0);
    write_reg(tpsp_pkg::CFG_SCALE, 32'd0);
    send_times(32'd7, 32'd1, 32'd1);
    send_times(32'd1, 32'd3, 32'd3);
    drain();

    // Phase 1: no idling, reset-like settings
    write_reg(tpsp_pkg::CFG_GAIN, 32'd256);
    write_reg(tpsp_pkg::CFG_OFFSET, 32'd256);
    write_reg(tpsp_pkg::CFG_SCALE, 32'd65536);
    send_random(300);
    drain();

    // Phase 2: sender mostly idle, strong gain
    write_reg(tpsp_pkg::CFG_GAIN, 32'd4096);
    write_reg(tpsp_pkg::CFG_OFFSET, 32'd384);
    write_reg(tpsp_pkg::CFG_SCALE, 32'd50000);
    send_idle_pct = 88;
    send_random(200);
    drain();

    // Phase 3: receiver mostly stalling, with one long hold-off that fills
    // the pipeline
    write_reg(tpsp_pkg::CFG_GAIN, $urandom_range(65535));
    write_reg(tpsp_pkg::CFG_OFFSET, $urandom_range(65535));
    write_reg(tpsp_pkg::CFG_SCALE, $urandom_range(65536));
    send_idle_pct = 0;
    recv_stall_pct = 88;
    @(negedge clk);
    hold_cycles = 400;
    send_random(200);
    drain();

    // Phase 4: both sides idle now and then
    write_reg(tpsp_pkg::CFG_GAIN, 32'd64);
    write_reg(tpsp_pkg::CFG_OFFSET, 32'd128);
    write_reg(tpsp_pkg::CFG_SCALE, 32'd65535);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    send_random(380);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[task_partition_sigmoid_probability.f]
+incdir+rtl/core
rtl/core/tpsp_pkg.sv
rtl/core/tpsp_if.sv
rtl/core/tpsp_div.sv
rtl/core/tpsp_exp.sv
rtl/core/task_partition_sigmoid_probability.sv
test/tb_task_partition_sigmoid_probability_checker.sv
test/tb_task_partition_sigmoid_probability.sv
